// File: design/trsp_pkg.sv
// Shared types and constants for the text region symbol placement core.
// No dependencies; imported by every module in this folder.
package trsp_pkg;

    localparam int DataW   = 32;
    localparam int SizeW   = 16;
    localparam int OffW    = 3;
    localparam int OpW     = 3;
    localparam int CfgIdxW = 3;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCntW   = $clog2(QDepth + 1);

    // input operation codes (5..7 are unused)
    typedef enum logic [OpW-1:0] {
        OP_REGION_START = 3'd0,
        OP_NEW_STRIP    = 3'd1,
        OP_FIRST_INST   = 3'd2,
        OP_NEXT_INST    = 3'd3,
        OP_STRIP_END    = 3'd4
    } t_op;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_LOG2_STRIPS    = 3'd0,
        CFG_DS_OFFSET      = 3'd1,
        CFG_TRANSPOSED     = 3'd2,
        CFG_REF_CORNER     = 3'd3,
        CFG_INSTANCE_TOTAL = 3'd4
    } t_cfg_idx;

    // work kinds that reach the back end
    typedef enum logic [1:0] {
        K_REGION = 2'd0,
        K_STRIP  = 2'd1,
        K_FIRST  = 2'd2,
        K_NEXT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]        log2_strips;
        logic signed [4:0] ds_offset;
        logic              transposed;
        logic [1:0]        ref_corner;
        logic [DataW-1:0]  instance_total;
    } t_cfg;

    // one classified item
    typedef struct packed {
        t_kind            kind;
        logic [DataW-1:0] value;   // shifted strip delta, S delta or S delta plus offset
        logic [DataW-1:0] t_adj;   // T-axis offset minus corner correction
        logic [DataW-1:0] adv;     // S advance (size - 1)
        logic [SizeW-1:0] width;
        logic [SizeW-1:0] height;
    } t_item;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [QCntW-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic             pop;
        logic             emit;
        t_kind            kind;
        logic [DataW-1:0] placed_count;
    } t_back_status;

endpackage

// File: design/text_region_symbol_placement_core.sv
// Text region symbol placement core: top level, configuration registers and
// checks. Depends on trsp_pkg, trsp_front, trsp_queue and trsp_back.

// The core takes decoded text region values (region start with initial strip
// T, new strip with strip delta, first instance with first S delta, next
// instance with S delta, strip end) and for every instance transfers the
// top-left corner of the symbol in the region, its size and a flag that is
// high on the instance that completes the configured instance count.
// Instances after that count are dropped without a result. Throughput is one
// input transfer per clock while the output side does not stall: the front
// end classifies each item in the cycle it arrives and the back end retires
// one queued item per cycle, its S update (running S plus delta plus advance)
// being the loop that sets that figure. A placed instance shows at the output
// in the cycle after it leaves the four-entry queue.
// Strip end and unused operation codes are absorbed in the input cycle and
// give no result. Input stall rises only when the queue is full, which
// happens only while the output side stalls. Configuration writes are meant
// for idle periods; registers reset to top-left corner, no transposition,
// single-row strips, zero offset and zero instances.
module text_region_symbol_placement_core
    import trsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [DataW-1:0]          i_cfg_data,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OpW-1:0]            i_operation,
    input  logic signed [DataW-1:0]   i_delta,
    input  logic [OffW-1:0]           i_strip_offset,
    input  logic [SizeW-1:0]          i_sym_width,
    input  logic [SizeW-1:0]          i_sym_height,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DataW-1:0]   o_place_x,
    output logic signed [DataW-1:0]   o_place_y,
    output logic [SizeW-1:0]          o_place_width,
    output logic [SizeW-1:0]          o_place_height,
    output logic                      o_last_instance
);

    t_cfg         r_cfg;
    t_item        front_item;
    t_item        q_head;
    t_q_status    q_status;
    t_back_status back_status;
    logic         front_push;
    logic         back_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log2_strips    <= 2'd0;
            r_cfg.ds_offset      <= 5'sd0;
            r_cfg.transposed     <= 1'b0;
            r_cfg.ref_corner     <= 2'd1;
            r_cfg.instance_total <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOG2_STRIPS:    r_cfg.log2_strips    <= i_cfg_data[1:0];
                CFG_DS_OFFSET:      r_cfg.ds_offset      <= $signed(i_cfg_data[4:0]);
                CFG_TRANSPOSED:     r_cfg.transposed     <= i_cfg_data[0];
                CFG_REF_CORNER:     r_cfg.ref_corner     <= i_cfg_data[1:0];
                CFG_INSTANCE_TOTAL: r_cfg.instance_total <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stalls only on a full queue; absorbed items still need a slot free
    assign o_in_stall = q_status.full;

    trsp_front u_front (
        .i_cfg          (r_cfg),
        .i_q_status     (q_status),
        .i_in_valid     (i_in_valid),
        .i_operation    (i_operation),
        .i_delta        (i_delta),
        .i_strip_offset (i_strip_offset),
        .i_sym_width    (i_sym_width),
        .i_sym_height   (i_sym_height),
        .o_push         (front_push),
        .o_item         (front_item)
    );

    trsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_item   (front_item),
        .i_pop    (back_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    trsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (q_head),
        .i_q_status      (q_status),
        .o_pop           (back_pop),
        .o_status        (back_status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_place_x       (o_place_x),
        .o_place_y       (o_place_y),
        .o_place_width   (o_place_width),
        .o_place_height  (o_place_height),
        .o_last_instance (o_last_instance)
    );

    // queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= QCntW'(QDepth))
        else $error("queue occupancy beyond depth");

    // the back end never retires from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // only instance items make a result, and a result is then shown
    a_emit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pop && back_status.emit |->
            ((back_status.kind == K_FIRST) || (back_status.kind == K_NEXT)) ##1 o_out_valid)
        else $error("result from a non-instance item");

    // a retired region start clears the instance count
    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pop && (back_status.kind == K_REGION) |=>
            (back_status.placed_count == '0))
        else $error("instance count not cleared by region start");

endmodule

// File: design/trsp_front.sv
// Front end: decodes the input item, masks the strip offset and works out the
// corner corrections and shifted deltas. Depends on trsp_pkg.
module trsp_front (
    input  trsp_pkg::t_cfg                       i_cfg,
    input  trsp_pkg::t_q_status                  i_q_status,
    input  logic                                 i_in_valid,
    input  logic [trsp_pkg::OpW-1:0]             i_operation,
    input  logic signed [trsp_pkg::DataW-1:0]    i_delta,
    input  logic [trsp_pkg::OffW-1:0]            i_strip_offset,
    input  logic [trsp_pkg::SizeW-1:0]           i_sym_width,
    input  logic [trsp_pkg::SizeW-1:0]           i_sym_height,
    output logic                                 o_push,
    output trsp_pkg::t_item                      o_item
);
    import trsp_pkg::*;

    logic [OffW-1:0]  off;
    logic [DataW-1:0] d_u;
    logic [DataW-1:0] d_shift;
    logic [DataW-1:0] ds_ext;
    logic [DataW-1:0] w_m1;
    logic [DataW-1:0] h_m1;
    logic [DataW-1:0] t_sub;
    logic             keep;

    always_comb begin
        off     = i_strip_offset & OffW'((4'd1 << i_cfg.log2_strips) - 4'd1);
        d_u     = DataW'(i_delta);
        d_shift = d_u << i_cfg.log2_strips;
        ds_ext  = {{(DataW-5){i_cfg.ds_offset[4]}}, i_cfg.ds_offset};
        w_m1    = {{(DataW-SizeW){1'b0}}, i_sym_width} - 32'd1;
        h_m1    = {{(DataW-SizeW){1'b0}}, i_sym_height} - 32'd1;

        // transposed: x is on T, corrected for right corners
        // otherwise:  y is on T, corrected for bottom corners
        if (i_cfg.transposed) begin
            o_item.adv = h_m1;
            t_sub      = i_cfg.ref_corner[1] ? w_m1 : '0;
        end else begin
            o_item.adv = w_m1;
            t_sub      = i_cfg.ref_corner[0] ? '0 : h_m1;
        end
        o_item.t_adj  = {{(DataW-OffW){1'b0}}, off} - t_sub;
        o_item.width  = i_sym_width;
        o_item.height = i_sym_height;

        keep = 1'b1;
        case (i_operation)
            OP_REGION_START: begin
                o_item.kind  = K_REGION;
                o_item.value = d_shift;
            end
            OP_NEW_STRIP: begin
                o_item.kind  = K_STRIP;
                o_item.value = d_shift;
            end
            OP_FIRST_INST: begin
                o_item.kind  = K_FIRST;
                o_item.value = d_u;
            end
            OP_NEXT_INST: begin
                o_item.kind  = K_NEXT;
                o_item.value = d_u + ds_ext;
            end
            default: begin
                // strip end and unused codes change nothing
                o_item.kind  = K_STRIP;
                o_item.value = '0;
                keep         = 1'b0;
            end
        endcase

        o_push = i_in_valid && !i_q_status.full && keep;
    end

endmodule

// File: design/trsp_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on trsp_pkg.
module trsp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  trsp_pkg::t_item     i_item,
    input  logic                i_pop,
    output trsp_pkg::t_item     o_head,
    output trsp_pkg::t_q_status o_status
);
    import trsp_pkg::*;

    t_item            r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCntW-1:0] r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_status.empty = (r_count == '0);
        o_status.full  = (r_count == QCntW'(QDepth));
        o_status.count = r_count;
        do_push  = i_push && !o_status.full;
        do_pop   = i_pop && !o_status.empty;
        n_wr_ptr = do_push ? r_wr_ptr + QPtrW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QPtrW'(1) : r_rd_ptr;
        n_count  = r_count + QCntW'(do_push) - QCntW'(do_pop);
        o_head   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/trsp_back.sv
// Back end: keeps strip T, first S, running S and instance count; places one
// instance per cycle into the output register when free. Depends on trsp_pkg.
module trsp_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  trsp_pkg::t_cfg                       i_cfg,
    input  trsp_pkg::t_item                      i_head,
    input  trsp_pkg::t_q_status                  i_q_status,
    output logic                                 o_pop,
    output trsp_pkg::t_back_status               o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [trsp_pkg::DataW-1:0]    o_place_x,
    output logic signed [trsp_pkg::DataW-1:0]    o_place_y,
    output logic [trsp_pkg::SizeW-1:0]           o_place_width,
    output logic [trsp_pkg::SizeW-1:0]           o_place_height,
    output logic                                 o_last_instance
);
    import trsp_pkg::*;

    logic [DataW-1:0] r_strip_t, n_strip_t;
    logic [DataW-1:0] r_first_s, n_first_s;
    logic [DataW-1:0] r_current_s, n_current_s;
    logic [DataW-1:0] r_placed_count, n_placed_count;
    logic             r_out_valid, n_out_valid;
    logic [DataW-1:0] r_x, r_y;
    logic [SizeW-1:0] r_w, r_h;
    logic             r_last;

    logic             is_inst, can_place, emit, out_free, pop;
    logic [DataW-1:0] base, tc, cnt_inc;

    always_comb begin
        is_inst   = (i_head.kind == K_FIRST) || (i_head.kind == K_NEXT);
        can_place = r_placed_count < i_cfg.instance_total;
        emit      = !i_q_status.empty && is_inst && can_place;
        out_free  = !r_out_valid || !i_out_stall;
        pop       = !i_q_status.empty && (!emit || out_free);

        // S coordinate before the advance; with the corner rules the placed
        // S edge always lands here and the advance only moves running S
        base    = (i_head.kind == K_FIRST) ? r_first_s + i_head.value
                                           : r_current_s + i_head.value;
        tc      = r_strip_t + i_head.t_adj;
        cnt_inc = r_placed_count + 32'd1;

        n_strip_t      = r_strip_t;
        n_first_s      = r_first_s;
        n_current_s    = r_current_s;
        n_placed_count = r_placed_count;
        if (pop) begin
            case (i_head.kind)
                K_REGION: begin
                    n_strip_t      = 32'd0 - i_head.value;
                    n_first_s      = '0;
                    n_current_s    = '0;
                    n_placed_count = '0;
                end
                K_STRIP: begin
                    n_strip_t = r_strip_t + i_head.value;
                end
                K_FIRST: begin
                    if (can_place) begin
                        n_first_s      = base;
                        n_current_s    = base + i_head.adv;
                        n_placed_count = cnt_inc;
                    end
                end
                K_NEXT: begin
                    if (can_place) begin
                        n_current_s    = base + i_head.adv;
                        n_placed_count = cnt_inc;
                    end
                end
                default: begin
                end
            endcase
        end

        if (pop && emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        o_pop             = pop;
        o_status.pop      = pop;
        o_status.emit     = emit;
        o_status.kind     = i_head.kind;
        o_status.placed_count = r_placed_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_t      <= '0;
            r_first_s      <= '0;
            r_current_s    <= '0;
            r_placed_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_strip_t      <= n_strip_t;
            r_first_s      <= n_first_s;
            r_current_s    <= n_current_s;
            r_placed_count <= n_placed_count;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_x    <= i_cfg.transposed ? tc : base;
            r_y    <= i_cfg.transposed ? base : tc;
            r_w    <= i_head.width;
            r_h    <= i_head.height;
            r_last <= (cnt_inc == i_cfg.instance_total);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_place_x       = $signed(r_x);
    assign o_place_y       = $signed(r_y);
    assign o_place_width   = r_w;
    assign o_place_height  = r_h;
    assign o_last_instance = r_last;

endmodule
